/* rtl/gsfm_pkg.sv */
package gsfm_pkg;

    // Frame store geometry.
    localparam int SAMPLE_DEPTH = 64;
    localparam int IDX_W        = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W        = $clog2(SAMPLE_DEPTH + 1);

    // Field and register widths.
    localparam int SAMPLE_W = 10;
    localparam int PPB_W    = 16;
    localparam int GAS_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths: the signed inner term, the scaled magnitude and the divisor.
    localparam int INNER_W = 28;
    localparam int NUM_W   = 37;
    localparam int DEN_W   = 26;
    localparam int STEP_W  = $clog2(NUM_W + 1);

    // Arithmetic constants.
    localparam int MUL_SCALE   = 1000;
    localparam int PPB_POS_MAX = 32767;
    localparam int PPB_NEG_MAX = 32768;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WE_ZERO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUX_ZERO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_CNT  = 3'd4;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCALE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_STORE,
        ST_MODE_I,
        ST_MODE_CAND,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

/* rtl/gsfm_div.sv */
module gsfm_div
    import gsfm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [NUM_W-1:0]  dvd_reg;
    logic [NUM_W-1:0]  dvd_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic              done_reg;
    logic              done_next;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;
    logic              take;

    // One restoring step per cycle; the quotient bits shift in where the dividend leaves.
    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[NUM_W-1]};
        rem_sub   = rem_sh - {1'b0, divisor};
        take      = (rem_sh >= {1'b0, divisor});
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            dvd_next = dividend;
            cnt_next = STEP_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            dvd_next = {dvd_reg[NUM_W-2:0], take};
            cnt_next = cnt_reg - STEP_W'(1);
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Working remainder and dividend/quotient shift register.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

/* rtl/gas_sensor_frame_mode.sv */
// Converts each item of working and auxiliary electrode readings into a
// concentration in ppb, saturated to signed 16 bits, and stores it in a
// 64-entry frame memory; once the frame is full (sample_count clamped to 1..64)
// it emits the most frequent value of the frame (earliest first occurrence wins
// a tie, negatives read as zero) and starts a new frame. Each item passes
// through the 37-step bit-serial divider that forms the quotient. The item
// that completes a frame adds a mode search over the clamped frame length,
// paced by the single read port of the frame memory that serves one comparison
// per cycle. in_stall is high for the whole of that work; a result held in
// the output register does not stop the next item from being taken. The
// frame memory needs no clearing pass after reset.
module gas_sensor_frame_mode
    import gsfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SAMPLE_W-1:0]   we_sample,
    input  logic [SAMPLE_W-1:0]   aux_sample,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [GAS_W-1:0]      gas_ppb
);

    // Configuration registers.
    logic [15:0]      supply_reg;
    logic [12:0]      we_zero_reg;
    logic [12:0]      aux_zero_reg;
    logic [15:0]      sens_reg;
    logic [CNT_W-1:0] sample_count_reg;

    // Sequencer and frame control.
    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] i_next;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] j_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // Datapath registers.
    logic [SAMPLE_W-1:0]       we_in_reg;
    logic [SAMPLE_W-1:0]       we_in_next;
    logic [SAMPLE_W-1:0]       aux_in_reg;
    logic [SAMPLE_W-1:0]       aux_in_next;
    logic signed [INNER_W-1:0] inner_reg;
    logic signed [INNER_W-1:0] inner_next;
    logic [DEN_W-1:0]          den_reg;
    logic [DEN_W-1:0]          den_next;
    logic [NUM_W-1:0]          num_reg;
    logic [NUM_W-1:0]          num_next;
    logic                      neg_reg;
    logic                      neg_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          best_count_reg;
    logic [CNT_W-1:0]          best_count_next;
    logic signed [PPB_W-1:0]   cand_reg;
    logic signed [PPB_W-1:0]   cand_next;
    logic signed [PPB_W-1:0]   best_reg;
    logic signed [PPB_W-1:0]   best_next;
    logic [GAS_W-1:0]          gas_reg;
    logic [GAS_W-1:0]          gas_next;

    // Frame memory.
    logic signed [PPB_W-1:0] mem [SAMPLE_DEPTH];
    logic signed [PPB_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    mem_we;

    // Combinational helpers.
    logic [CNT_W-1:0]          frame_len;
    logic [IDX_W-1:0]          frame_last;
    logic [IDX_W-1:0]          wr_idx;
    logic [CNT_W-1:0]          fill_new;
    logic [15:0]               sens_eff;
    logic signed [INNER_W-1:0] diff_s;
    logic signed [INNER_W-1:0] supply_s;
    logic signed [INNER_W-1:0] zero_s;
    logic [INNER_W-1:0]        inner_mag;
    logic signed [PPB_W-1:0]   ppb_val;
    logic [CNT_W-1:0]          cnt_inc;
    logic                      div_start;
    logic                      div_done;
    logic [NUM_W-1:0]          div_q;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg       <= 16'd4980;
            we_zero_reg      <= 13'd362;
            aux_zero_reg     <= 13'd341;
            sens_reg         <= 16'd300;
            sample_count_reg <= CNT_W'(60);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SUPPLY:      supply_reg       <= cfg_data;
                REG_WE_ZERO:     we_zero_reg      <= cfg_data[12:0];
                REG_AUX_ZERO:    aux_zero_reg     <= cfg_data[12:0];
                REG_SENSITIVITY: sens_reg         <= cfg_data;
                REG_SAMPLE_CNT:  sample_count_reg <= cfg_data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Frame length clamped to the store depth, and the write slot of this item.
    always_comb
    begin
        if (sample_count_reg == '0)
        begin
            frame_len = CNT_W'(1);
        end
        else if (sample_count_reg > CNT_W'(SAMPLE_DEPTH))
        begin
            frame_len = CNT_W'(SAMPLE_DEPTH);
        end
        else
        begin
            frame_len = sample_count_reg;
        end
        frame_last = IDX_W'(frame_len - CNT_W'(1));
        wr_idx     = (fill_reg >= CNT_W'(SAMPLE_DEPTH)) ? '0 : fill_reg[IDX_W-1:0];
        fill_new   = CNT_W'(wr_idx) + CNT_W'(1);
    end

    // Operands of the numerator and divisor.
    always_comb
    begin
        sens_eff  = (sens_reg == '0) ? 16'd1 : sens_reg;
        diff_s    = $signed(INNER_W'(we_in_reg)) - $signed(INNER_W'(aux_in_reg));
        supply_s  = $signed(INNER_W'(supply_reg));
        zero_s    = $signed(INNER_W'(we_zero_reg)) - $signed(INNER_W'(aux_zero_reg));
        inner_mag = inner_reg[INNER_W-1] ? INNER_W'(-inner_reg) : INNER_W'(inner_reg);
    end

    // Sign and saturation of the quotient.
    always_comb
    begin
        if (neg_reg)
        begin
            if (div_q > NUM_W'(PPB_NEG_MAX))
            begin
                ppb_val = $signed(PPB_W'(PPB_NEG_MAX));
            end
            else
            begin
                ppb_val = $signed(PPB_W'(0) - div_q[PPB_W-1:0]);
            end
        end
        else
        begin
            if (div_q > NUM_W'(PPB_POS_MAX))
            begin
                ppb_val = $signed(PPB_W'(PPB_POS_MAX));
            end
            else
            begin
                ppb_val = $signed(div_q[PPB_W-1:0]);
            end
        end
    end

    assign cnt_inc = count_reg + CNT_W'(rd_data_reg == cand_reg);

    // Sequencer: conversion, store, and, once a frame is full, the mode search over it and the output.
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        out_valid_next  = out_valid_reg & out_stall;
        we_in_next      = we_in_reg;
        aux_in_next     = aux_in_reg;
        inner_next      = inner_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        neg_next        = neg_reg;
        count_next      = count_reg;
        best_count_next = best_count_reg;
        cand_next       = cand_reg;
        best_next       = best_reg;
        gas_next        = gas_reg;
        rd_addr         = i_reg;
        mem_we          = 1'b0;
        div_start       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    we_in_next  = we_sample;
                    aux_in_next = aux_sample;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                inner_next = diff_s * supply_s - ((zero_s <<< 10) - zero_s);
                den_next   = (DEN_W'(sens_eff) << 10) - DEN_W'(sens_eff);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                num_next   = NUM_W'(inner_mag) * NUM_W'(MUL_SCALE);
                neg_next   = inner_reg[INNER_W-1];
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                mem_we = 1'b1;
                if (fill_new < frame_len)
                begin
                    fill_next  = fill_new;
                    state_next = ST_IDLE;
                end
                else
                begin
                    fill_next       = '0;
                    i_next          = '0;
                    best_count_next = '0;
                    best_next       = '0;
                    state_next      = ST_MODE_I;
                end
            end
            ST_MODE_I:
            begin
                rd_addr    = i_reg;
                state_next = ST_MODE_CAND;
            end
            ST_MODE_CAND:
            begin
                cand_next  = rd_data_reg;
                rd_addr    = '0;
                j_next     = '0;
                count_next = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                rd_addr = j_reg + IDX_W'(1);
                if (j_reg == frame_last)
                begin
                    if (cnt_inc > best_count_reg)
                    begin
                        best_count_next = cnt_inc;
                        best_next       = cand_reg;
                    end
                    if (i_reg == frame_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = ST_MODE_I;
                    end
                end
                else
                begin
                    count_next = cnt_inc;
                    j_next     = j_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    gas_next       = best_reg[PPB_W-1] ? '0 : best_reg[GAS_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register and frame control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        we_in_reg      <= we_in_next;
        aux_in_reg     <= aux_in_next;
        inner_reg      <= inner_next;
        den_reg        <= den_next;
        num_reg        <= num_next;
        neg_reg        <= neg_next;
        count_reg      <= count_next;
        best_count_reg <= best_count_next;
        cand_reg       <= cand_next;
        best_reg       <= best_next;
        gas_reg        <= gas_next;
    end

    // Frame memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx] <= ppb_val;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Bit-serial divider for the quotient.
    gsfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign gas_ppb   = gas_reg;

`ifndef SYNTHESIS
    // The stored count never passes the depth of the frame memory.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(SAMPLE_DEPTH))
        else $error("fill count beyond frame depth");

    // A new result only appears out of the final sequencer step.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final step");

    // The divider only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    // The mode search indexes stay inside the frame.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((j_reg <= frame_last) && (i_reg <= frame_last)))
        else $error("mode search index outside the frame");
`endif

endmodule

/* dv/gas_sensor_frame_mode_test.sv */
`timescale 1ns / 1ps

module gas_sensor_frame_mode_test;

    import gsfm_pkg::*;

    // Kinds of rows in the directed plan.
    typedef enum logic {
        ROW_PAIR,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [SAMPLE_W-1:0]   we;
        logic [SAMPLE_W-1:0]   aux;
        bit                    known;
        logic [GAS_W-1:0]      gas;
    } plan_row_t;

    localparam int RANDOM_ITEMS = 1800;
    localparam int SETTLE_CYCLES = 64;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   we_sample = '0;
    logic [SAMPLE_W-1:0]   aux_sample = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [GAS_W-1:0]      gas_ppb;

    // Predictor copy of the registers and the frame.
    logic [15:0]        supply_r;
    logic [12:0]        we_zero_r;
    logic [12:0]        aux_zero_r;
    logic [15:0]        sens_r;
    logic [6:0]         frame_len_r;
    logic signed [15:0] ppb_frame [SAMPLE_DEPTH];
    int                 frame_fill;

    logic [GAS_W-1:0] gas_q [$];
    plan_row_t        plan [$];

    bit calm = 1'b0;
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int reg_writes = 0;
    int phases = 0;

    gas_sensor_frame_mode i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .we_sample  (we_sample),
        .aux_sample (aux_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .gas_ppb    (gas_ppb)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Concentration of one electrode pair, saturated to signed 16 bits.
    function automatic logic signed [15:0] ppb_of_pair(logic [SAMPLE_W-1:0] we,
                                                       logic [SAMPLE_W-1:0] aux);
        longint diff;
        longint zero;
        longint sens;
        longint num;
        longint q;
        diff = longint'(we) - longint'(aux);
        zero = longint'(we_zero_r) - longint'(aux_zero_r);
        sens = (sens_r == 0) ? 1 : longint'(sens_r);
        num = 1000 * (diff * longint'(supply_r) - zero * 1023);
        q = num / (1023 * sens);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    // Most frequent value among the first n stored entries; the earliest
    // first occurrence wins a tie.
    function automatic logic signed [15:0] frame_mode_of(int n);
        logic signed [15:0] best;
        int best_cnt;
        int cnt;
        best = 0;
        best_cnt = 0;
        for (int i = 0; i < n; i++)
        begin
            cnt = 0;
            for (int j = 0; j < n; j++)
                if (ppb_frame[j] == ppb_frame[i])
                    cnt++;
            if (cnt > best_cnt)
            begin
                best_cnt = cnt;
                best = ppb_frame[i];
            end
        end
        return best;
    endfunction

    // Store one pair and tell whether it closes the frame, and with what mode.
    function automatic void store_pair(input logic [SAMPLE_W-1:0] we,
                                       input logic [SAMPLE_W-1:0] aux,
                                       output bit due, output logic [GAS_W-1:0] gas);
        int len;
        logic signed [15:0] m;
        len = int'(frame_len_r);
        if (len < 1)
            len = 1;
        if (len > SAMPLE_DEPTH)
            len = SAMPLE_DEPTH;
        if (frame_fill >= SAMPLE_DEPTH)
            frame_fill = 0;
        ppb_frame[frame_fill] = ppb_of_pair(we, aux);
        frame_fill++;
        due = (frame_fill >= len);
        gas = '0;
        if (due)
        begin
            m = frame_mode_of(len);
            frame_fill = 0;
            gas = (m < 0) ? '0 : m[GAS_W-1:0];
        end
    endfunction

    function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r = '{ROW_CFG, idx, val, '0, '0, 1'b0, '0};
        plan.push_back(r);
    endfunction

    function automatic void plan_pair(logic [SAMPLE_W-1:0] we, logic [SAMPLE_W-1:0] aux);
        plan_row_t r;
        r = '{ROW_PAIR, '0, '0, we, aux, 1'b0, '0};
        plan.push_back(r);
    endfunction

    function automatic void plan_known(logic [SAMPLE_W-1:0] we, logic [SAMPLE_W-1:0] aux,
                                       logic [GAS_W-1:0] gas);
        plan_row_t r;
        r = '{ROW_PAIR, '0, '0, we, aux, 1'b1, gas};
        plan.push_back(r);
    endfunction

    // Random register value, weighted toward the extremes.
    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] v;
        int r;
        v = '0;
        r = $urandom_range(0, 99);
        case (idx)
            REG_SUPPLY:
            begin
                if (r < 15)
                    v = 16'd0;
                else if (r < 30)
                    v = 16'hFFFF;
                else if (r < 45)
                    v = 16'd4980;
                else
                    v = CFG_DATA_W'($urandom_range(0, 65535));
            end
            REG_WE_ZERO, REG_AUX_ZERO:
            begin
                if (r < 15)
                    v = 16'd0;
                else if (r < 30)
                    v = 16'd5000;
                else if (r < 40)
                    v = 16'h1FFF;
                else
                    v = CFG_DATA_W'($urandom_range(0, 5000));
                // Bits above the register width are dropped.
                if ($urandom_range(0, 99) < 20)
                    v[15:13] = 3'($urandom_range(0, 7));
            end
            REG_SENSITIVITY:
            begin
                if (r < 10)
                    v = 16'd0;
                else if (r < 20)
                    v = 16'd1;
                else if (r < 30)
                    v = 16'hFFFF;
                else if (r < 65)
                    v = CFG_DATA_W'($urandom_range(1, 400));
                else
                    v = CFG_DATA_W'($urandom_range(1, 65535));
            end
            REG_SAMPLE_CNT:
            begin
                // Mostly short frames; long and out-of-range ones now and then.
                if (r < 65)
                    v = CFG_DATA_W'($urandom_range(1, 8));
                else if (r < 80)
                    v = CFG_DATA_W'($urandom_range(9, 24));
                else if (r < 88)
                    v = 16'd64;
                else if (r < 94)
                    v = 16'd0;
                else
                    v = CFG_DATA_W'($urandom_range(65, 127));
                if ($urandom_range(0, 99) < 20)
                    v[15:7] = 9'($urandom_range(0, 511));
            end
            default:
                v = '0;
        endcase
        return v;
    endfunction

    // One register write on the configuration port, mirrored in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SUPPLY:      supply_r = val;
            REG_WE_ZERO:     we_zero_r = val[12:0];
            REG_AUX_ZERO:    aux_zero_r = val[12:0];
            REG_SENSITIVITY: sens_r = val;
            REG_SAMPLE_CNT:  frame_len_r = val[6:0];
            default:         ;
        endcase
        reg_writes++;
        @(negedge clk);
    endtask

    // Hold the input side until every expected result has come.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (gas_q.size() != 0)
            @(negedge clk);
    endtask

    // Drain, then give a pair that closes no frame time to finish.
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Offer one item, wait for it to be taken, and record the expected result.
    task automatic push_pair(input logic [SAMPLE_W-1:0] we, input logic [SAMPLE_W-1:0] aux,
                             input bit known, input logic [GAS_W-1:0] known_gas);
        bit due;
        logic [GAS_W-1:0] gas;
        while (!calm && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        we_sample <= we;
        aux_sample <= aux;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        store_pair(we, aux, due, gas);
        if (due)
            gas_q.push_back(known ? known_gas : gas);
        items_sent++;
        @(negedge clk);
    endtask

    // Receiver stalls at random except during the calm stretch.
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 20);

    // Compare each taken result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (gas_q.size() == 0)
            begin
                $error("gas_ppb: result with no expectation, actual %0d", gas_ppb);
                errors++;
            end
            else if (gas_ppb !== gas_q[0])
            begin
                $error("gas_ppb: expected %0d, actual %0d", gas_q[0], gas_ppb);
                errors++;
                void'(gas_q.pop_front());
            end
            else
                void'(gas_q.pop_front());
        end
    end

    initial
    begin
        #30_000_000;
        $display("gas_sensor_frame_mode_test: FAIL");
        $finish;
    end

    initial
    begin
        logic [SAMPLE_W-1:0] pool_we [4];
        logic [SAMPLE_W-1:0] pool_aux [4];
        logic [SAMPLE_W-1:0] we;
        logic [SAMPLE_W-1:0] aux;
        int random_sent;
        int plen;
        int pick;
        int r;

        // Register values after reset.
        supply_r = 16'd4980;
        we_zero_r = 13'd362;
        aux_zero_r = 13'd341;
        sens_r = 16'd300;
        frame_len_r = 7'd60;
        frame_fill = 0;
        foreach (ppb_frame[i])
            ppb_frame[i] = '0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings, one-item frames: negative clamps to zero, full scale.
        plan_cfg(REG_SAMPLE_CNT, 16'd1);
        plan_known(10'd0, 10'd0, 15'd0);
        plan_known(10'd1023, 10'd0, 15'd16530);
        // Saturation both ways.
        plan_cfg(REG_SUPPLY, 16'hFFFF);
        plan_cfg(REG_WE_ZERO, 16'd0);
        plan_cfg(REG_AUX_ZERO, 16'd0);
        plan_cfg(REG_SENSITIVITY, 16'd1);
        plan_known(10'd1023, 10'd0, 15'd32767);
        plan_known(10'd0, 10'd1023, 15'd0);
        // Zero sensitivity acts as one: each step of the difference is 1000 ppb.
        plan_cfg(REG_SENSITIVITY, 16'd0);
        plan_cfg(REG_SUPPLY, 16'd1023);
        plan_known(10'd1, 10'd0, 15'd1000);
        plan_known(10'd5, 10'd2, 15'd3000);
        // Tie between two values: the earlier one wins.
        plan_cfg(REG_SAMPLE_CNT, 16'd5);
        plan_pair(10'd3, 10'd0);
        plan_pair(10'd5, 10'd0);
        plan_pair(10'd5, 10'd0);
        plan_pair(10'd3, 10'd0);
        plan_pair(10'd7, 10'd0);
        // Negative mode.
        plan_cfg(REG_SAMPLE_CNT, 16'd3);
        plan_pair(10'd0, 10'd2);
        plan_pair(10'd1, 10'd0);
        plan_pair(10'd0, 10'd2);
        // Frame length lowered below the stored count mid-frame.
        plan_cfg(REG_SAMPLE_CNT, 16'd6);
        plan_pair(10'd9, 10'd0);
        plan_pair(10'd4, 10'd0);
        plan_pair(10'd4, 10'd0);
        plan_pair(10'd9, 10'd0);
        plan_cfg(REG_SAMPLE_CNT, 16'd2);
        plan_pair(10'd4, 10'd0);
        // Frame length of zero acts as one; zero offsets at their extremes.
        plan_cfg(REG_SAMPLE_CNT, 16'd0);
        plan_cfg(REG_SUPPLY, 16'd0);
        plan_cfg(REG_SENSITIVITY, 16'hFFFF);
        plan_cfg(REG_WE_ZERO, 16'd5000);
        plan_pair(10'd0, 10'd0);
        plan_cfg(REG_WE_ZERO, 16'd0);
        plan_cfg(REG_AUX_ZERO, 16'd5000);
        plan_pair(10'd1023, 10'd1023);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                push_pair(plan[i].we, plan[i].aux, plan[i].known, plan[i].gas);
        end

        // Random phases: new settings, then items drawn mostly from a small set of
        // pairs so that frames hold repeated values and ties.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            calm = (phases == 4);
            for (int k = 0; k < 5; k++)
                if (phases == 0 || $urandom_range(0, 99) < 50)
                    write_reg(k[CFG_IDX_W-1:0], pick_reg_value(k[CFG_IDX_W-1:0]));
            for (int k = 0; k < 4; k++)
            begin
                pool_we[k] = SAMPLE_W'($urandom_range(0, 1023));
                pool_aux[k] = SAMPLE_W'($urandom_range(0, 1023));
            end
            plen = calm ? 200 : $urandom_range(8, 100);
            for (int k = 0; k < plen; k++)
            begin
                r = $urandom_range(0, 99);
                pick = $urandom_range(0, 3);
                if (r < 70)
                begin
                    we = pool_we[pick];
                    aux = pool_aux[pick];
                end
                else if (r < 78)
                begin
                    we = pick[0] ? 10'd1023 : 10'd0;
                    aux = pick[1] ? 10'd1023 : 10'd0;
                end
                else
                begin
                    we = SAMPLE_W'($urandom_range(0, 1023));
                    aux = SAMPLE_W'($urandom_range(0, 1023));
                end
                push_pair(we, aux, 1'b0, '0);
                random_sent++;
                // Sender holds off once until the output side has caught up.
                if (phases == 2 && k == plen / 2)
                    drain_results();
            end
            phases++;
        end

        drain_results();
        repeat (200) @(negedge clk);
        if (gas_q.size() != 0)
        begin
            $error("gas_ppb: %0d expected results never came", gas_q.size());
            errors++;
        end

        $display("Covered %0d items over %0d random phases with %0d register writes.",
                 items_sent, phases, reg_writes);
        $display("Checked %0d frame results with random stalls on both sides.", results_seen);
        if (errors == 0)
            $display("gas_sensor_frame_mode_test: PASS");
        else
            $display("gas_sensor_frame_mode_test: FAIL");
        $finish;
    end

endmodule

/* gas_sensor_frame_mode.f */
rtl/gsfm_pkg.sv
rtl/gsfm_div.sv
rtl/gas_sensor_frame_mode.sv
dv/gas_sensor_frame_mode_test.sv
